/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* src/pde_pkg.sv */
// ----------------------------------------------------------------------------
// pde_pkg
// Types, constants and coefficient scaling shared by the derivative evaluator.
// ----------------------------------------------------------------------------
package pde_pkg;

  localparam int MAX_DEGREE = 7;
  localparam int NUM_COEF   = 8;
  localparam int COEF_W     = 32;
  localparam int ACC_W      = 64;
  localparam int ORDER_W    = 4;
  localparam int IDX_W      = 4;
  localparam int SCALE_W    = 13;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_COEF-1:0]     coef_arr_t;

  // One request in flight between pipeline sections
  typedef struct packed {
    logic                    valid;
    logic signed [ACC_W-1:0] acc;
    logic signed [COEF_W-1:0] x;
    logic [ORDER_W-1:0]      k;
    logic                    ovf;
  } pde_item_t;

  // Falling factorial (j+k)!/j!, zero where j+k runs past the top degree
  localparam logic [SCALE_W-1:0] SCALE_TAB [8][8] = '{
    '{13'd1, 13'd1, 13'd2,  13'd6,   13'd24,  13'd120,  13'd720, 13'd5040},
    '{13'd1, 13'd2, 13'd6,  13'd24,  13'd120, 13'd720,  13'd5040, 13'd0},
    '{13'd1, 13'd3, 13'd12, 13'd60,  13'd360, 13'd2520, 13'd0,   13'd0},
    '{13'd1, 13'd4, 13'd20, 13'd120, 13'd840, 13'd0,    13'd0,   13'd0},
    '{13'd1, 13'd5, 13'd30, 13'd210, 13'd0,   13'd0,    13'd0,   13'd0},
    '{13'd1, 13'd6, 13'd42, 13'd0,   13'd0,   13'd0,    13'd0,   13'd0},
    '{13'd1, 13'd7, 13'd0,  13'd0,   13'd0,   13'd0,    13'd0,   13'd0},
    '{13'd1, 13'd0, 13'd0,  13'd0,   13'd0,   13'd0,    13'd0,   13'd0}
  };

  // Derived coefficient d_j = coef_(j+k) * (j+k)!/j!, exact in 64 bits
  function automatic logic signed [ACC_W-1:0] derive_coef(
    input coef_arr_t          coefs,
    input logic [2:0]         j,
    input logic [ORDER_W-1:0] k
  );
    logic [4:0]              sum;
    logic [SCALE_W-1:0]      sc;
    logic signed [COEF_W-1:0] c;
    logic signed [45:0]      p;
    sum = {2'b00, j} + {1'b0, k};
    if (sum > 5'(MAX_DEGREE)) begin
      return '0;
    end
    c  = coefs[sum[2:0]];
    sc = SCALE_TAB[j][k[2:0]];
    p  = 46'(c) * 46'($signed({1'b0, sc}));
    return {{(ACC_W-46){p[45]}}, p};
  endfunction

endpackage

/* src/pde_coef_regs.sv */
// ----------------------------------------------------------------------------
// pde_coef_regs
// Coefficient register file written through the configuration port.
// ----------------------------------------------------------------------------
module pde_coef_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pde_pkg::IDX_W-1:0]       cfg_index,
  input  logic [pde_pkg::COEF_W-1:0]      cfg_data,
  output pde_pkg::coef_arr_t              coefs
);

  pde_pkg::coef_arr_t coef_r;

  // Write the addressed coefficient; drop writes past the register list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_we && (cfg_index < pde_pkg::IDX_W'(pde_pkg::NUM_COEF))) begin
      coef_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  assign coefs = coef_r;

endmodule

/* src/pde_horner_step.sv */
// ----------------------------------------------------------------------------
// pde_horner_step
// One Horner step in four stages: acc = sat(sat((acc * x) >>> 16) + d_j).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pde_horner_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [2:0]          step_j,
  input  pde_pkg::coef_arr_t  coefs,
  input  pde_pkg::pde_item_t  in_item,
  output pde_pkg::pde_item_t  out_item
);

  localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};

  // Stage 1: low partial product and derived coefficient
  logic               s1_v_r;
  logic signed [63:0] s1_plo_r;
  logic signed [31:0] s1_ahi_r;
  logic signed [31:0] s1_x_r;
  logic [3:0]         s1_k_r;
  logic               s1_ovf_r;
  logic signed [63:0] s1_d_r;
  logic signed [63:0] plo_nxt;

  assign plo_nxt = 64'($signed({1'b0, in_item.acc[31:0]})) * 64'(in_item.x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_plo_r <= plo_nxt;
      s1_ahi_r <= in_item.acc[63:32];
      s1_x_r   <= in_item.x;
      s1_k_r   <= in_item.k;
      s1_ovf_r <= in_item.ovf;
      s1_d_r   <= pde_pkg::derive_coef(coefs, step_j, in_item.k);
    end
  end

  // Stage 2: high partial product
  logic               s2_v_r;
  logic signed [63:0] s2_plo_r;
  logic signed [63:0] s2_phi_r;
  logic signed [31:0] s2_x_r;
  logic [3:0]         s2_k_r;
  logic               s2_ovf_r;
  logic signed [63:0] s2_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_phi_r <= 64'(s1_ahi_r) * 64'(s1_x_r);
      s2_plo_r <= s1_plo_r;
      s2_x_r   <= s1_x_r;
      s2_k_r   <= s1_k_r;
      s2_ovf_r <= s1_ovf_r;
      s2_d_r   <= s1_d_r;
    end
  end

  // Stage 3: combine partials, shift by 16 and saturate to 64 bits
  logic               s3_v_r;
  logic signed [63:0] s3_m_r;
  logic signed [31:0] s3_x_r;
  logic [3:0]         s3_k_r;
  logic               s3_ovf_r;
  logic signed [63:0] s3_d_r;
  logic signed [95:0] full_nxt;
  logic               fits_nxt;
  logic signed [63:0] m_nxt;

  always_comb begin
    full_nxt = $signed({s2_phi_r, 32'd0}) + {{32{s2_plo_r[63]}}, s2_plo_r};
    fits_nxt = (full_nxt[95:79] == {17{full_nxt[79]}});
    if (fits_nxt) begin
      m_nxt = full_nxt[79:16];
    end else if (full_nxt[95]) begin
      m_nxt = SAT_MIN;
    end else begin
      m_nxt = SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_m_r   <= m_nxt;
      s3_x_r   <= s2_x_r;
      s3_k_r   <= s2_k_r;
      s3_ovf_r <= s2_ovf_r | ~fits_nxt;
      s3_d_r   <= s2_d_r;
    end
  end

  // Stage 4: saturating add of the derived coefficient
  pde_pkg::pde_item_t out_r;
  logic signed [63:0] sum_nxt;
  logic               add_ovf_nxt;
  logic signed [63:0] acc_nxt;

  always_comb begin
    sum_nxt     = s3_m_r + s3_d_r;
    add_ovf_nxt = (s3_m_r[63] == s3_d_r[63]) && (sum_nxt[63] != s3_m_r[63]);
    if (!add_ovf_nxt) begin
      acc_nxt = sum_nxt;
    end else if (s3_m_r[63]) begin
      acc_nxt = SAT_MIN;
    end else begin
      acc_nxt = SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (adv) begin
      out_r.valid <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.acc <= acc_nxt;
      out_r.x   <= s3_x_r;
      out_r.k   <= s3_k_r;
      out_r.ovf <= s3_ovf_r | add_ovf_nxt;
    end
  end

  assign out_item = out_r;

  // An order above the degree carries a clean zero through every step
  `ASSERT_PROP(a_high_order_zero, clk, rst_n, in_item.valid && (in_item.k > 4'(pde_pkg::MAX_DEGREE)) |-> (in_item.acc == 64'sd0) && !in_item.ovf, "high order request carries nonzero state")
  // A set overflow flag is never lost on entry to the step
  `ASSERT_PROP(a_ovf_sticky, clk, rst_n, $past(rst_n) && $past(adv) && $past(in_item.valid) && $past(in_item.ovf) |-> s1_ovf_r, "overflow flag dropped in step")

endmodule

/* src/polynomial_derivative_evaluator.sv */
// Pipeline: one entry stage plus seven Horner steps of four stages each: two
//   partial products, shift and saturate, saturating add.
// Throughput: one request per cycle; an output stall holds the whole pipeline.
// Reset: synchronous active-low rst_n clears all valid bits and the coefficients.
// ----------------------------------------------------------------------------
// polynomial_derivative_evaluator
// k-th derivative of a degree-7 Q16.16 polynomial at x, saturated to 64 bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polynomial_derivative_evaluator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pde_pkg::IDX_W-1:0]          cfg_index,
  input  logic [pde_pkg::COEF_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [pde_pkg::COEF_W-1:0]  in_x_value,
  input  logic [pde_pkg::ORDER_W-1:0]        in_deriv_order,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pde_pkg::ACC_W-1:0]   out_result_value,
  output logic                               out_overflow
);

  pde_pkg::coef_arr_t coefs;
  pde_pkg::pde_item_t chain [pde_pkg::MAX_DEGREE+1];
  pde_pkg::pde_item_t front_r;
  logic               adv;

  pde_coef_regs u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  // Advance the pipeline unless the result register holds an untaken request
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Entry stage: seed the accumulator with the top derived coefficient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else if (adv) begin
      front_r.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      front_r.acc <= pde_pkg::derive_coef(coefs, 3'(pde_pkg::MAX_DEGREE), in_deriv_order);
      front_r.x   <= in_x_value;
      front_r.k   <= in_deriv_order;
      front_r.ovf <= 1'b0;
    end
  end

  assign chain[0] = front_r;

  // Horner steps from the top coefficient down to d_0
  for (genvar g = 0; g < pde_pkg::MAX_DEGREE; g++) begin : g_step
    pde_horner_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .step_j   (3'(pde_pkg::MAX_DEGREE - 1 - g)),
      .coefs    (coefs),
      .in_item  (chain[g]),
      .out_item (chain[g+1])
    );
  end

  assign out_valid        = chain[pde_pkg::MAX_DEGREE].valid;
  assign out_result_value = chain[pde_pkg::MAX_DEGREE].acc;
  assign out_overflow     = chain[pde_pkg::MAX_DEGREE].ovf;

  // An accepted request lands in the entry stage on the next edge
  `ASSERT_PROP(a_accept_enters, clk, rst_n, $past(rst_n) && $past(in_valid && in_ready) |-> front_r.valid, "accepted request missing from entry stage")
  // Order equal to the degree is an exact product and cannot overflow
  `ASSERT_PROP(a_top_order_exact, clk, rst_n, out_valid && (chain[pde_pkg::MAX_DEGREE].k == 4'(pde_pkg::MAX_DEGREE)) |-> !out_overflow, "overflow on top order result")

endmodule

/* tb/polynomial_derivative_evaluator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_derivative_evaluator_tb
// Self-checking bench for the Q16.16 polynomial derivative evaluator. Loads
// coefficient sets from zero through the signed extremes and sends directed
// and random requests (x, order) with idle, stall and back-pressure phases.
// Each result is checked against a bit-exact Horner prediction.
// ----------------------------------------------------------------------------
module polynomial_derivative_evaluator_tb;

  localparam int ACC_W      = pde_pkg::ACC_W;
  localparam int COEF_W     = pde_pkg::COEF_W;
  localparam int ORDER_W    = pde_pkg::ORDER_W;
  localparam int IDX_W      = pde_pkg::IDX_W;
  localparam int NUM_COEF   = pde_pkg::NUM_COEF;
  localparam int MAX_DEGREE = pde_pkg::MAX_DEGREE;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] Q_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] Q_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam int FIRST_UNUSED_INDEX = NUM_COEF;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int PRESSURE_ITEMS = 120;

  typedef struct {
    logic signed [COEF_W-1:0] x;
    logic [ORDER_W-1:0]       k;
  } deriv_request_t;

  typedef struct {
    logic signed [ACC_W-1:0] value;
    logic                    ovf;
  } deriv_result_t;

  // DUT signals
  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [IDX_W-1:0]          cfg_index = '0;
  logic [COEF_W-1:0]         cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COEF_W-1:0]  in_x_value = '0;
  logic [ORDER_W-1:0]        in_deriv_order = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [ACC_W-1:0]   out_result_value;
  logic                      out_overflow;

  // Bench state
  logic signed [COEF_W-1:0]  coef_shadow [NUM_COEF];
  deriv_request_t            pending_requests [$];
  deriv_result_t             expected_results [$];
  deriv_request_t            next_req;
  deriv_result_t             oldest_result;
  int                        in_idle_pct = 0;
  int                        out_idle_pct = 0;
  int                        hold_trigger = 0;
  int                        hold_seen = 0;
  int                        hold_left = 0;
  int                        error_count = 0;

  polynomial_derivative_evaluator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_x_value       (in_x_value),
    .in_deriv_order   (in_deriv_order),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_overflow     (out_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Coefficient of x^j in the k-th derivative: coef_(j+k) * (j+k)!/j!
  function automatic longint scaled_coef(input int j, input int k);
    longint scale;
    longint c;
    int     m;
    scale = 1;
    for (m = j + 1; m <= j + k; m++) begin
      scale = scale * m;
    end
    c = longint'(coef_shadow[j + k]);
    return c * scale;
  endfunction

  // (a * x) >>> 16 at full precision, saturated to 64 bits
  function automatic logic signed [ACC_W-1:0] mul_q16_sat(
    input logic signed [ACC_W-1:0]  a,
    input logic signed [COEF_W-1:0] x,
    inout logic                     ovf
  );
    logic signed [95:0] prod;
    logic signed [95:0] shifted;
    prod = 96'(a) * 96'(x);
    shifted = prod >>> 16;
    if (shifted[95:63] == {33{1'b0}} || shifted[95:63] == {33{1'b1}}) begin
      return shifted[63:0];
    end
    ovf = 1'b1;
    return shifted[95] ? ACC_MIN : ACC_MAX;
  endfunction

  // Signed 64-bit add with saturation
  function automatic logic signed [ACC_W-1:0] add_sat(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b,
    inout logic                    ovf
  );
    logic [ACC_W:0] sum;
    sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      ovf = 1'b1;
      return sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return sum[ACC_W-1:0];
  endfunction

  // Horner evaluation of the k-th derivative from the top coefficient down
  function automatic deriv_result_t predict_derivative(
    input logic signed [COEF_W-1:0] x,
    input logic [ORDER_W-1:0]       k
  );
    deriv_result_t           r;
    logic signed [ACC_W-1:0] acc;
    logic                    ovf;
    int                      j;
    int                      order;
    order = int'(k);
    acc = '0;
    ovf = 1'b0;
    if (order <= MAX_DEGREE) begin
      acc = scaled_coef(MAX_DEGREE - order, order);
      for (j = MAX_DEGREE - order; j > 0; j--) begin
        acc = mul_q16_sat(acc, x, ovf);
        acc = add_sat(acc, scaled_coef(j - 1, order), ovf);
      end
    end
    r.value = acc;
    r.ovf = ovf;
    return r;
  endfunction

  // Driver: offer queued requests, predict each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_derivative(in_x_value, in_deriv_order));
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          next_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_x_value <= next_req.x;
          in_deriv_order <= next_req.k;
        end else begin
          in_valid <= 1'b0;
          in_x_value <= $urandom;
          in_deriv_order <= ORDER_W'($urandom);
        end
      end
    end
  end

  // Long output hold-off, started by a toggle of hold_trigger
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_trigger) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_trigger;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending: value %h ovf %b",
                 $time, out_result_value, out_overflow);
        error_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_result_value !== oldest_result.value) begin
          $display("%0t: result_value mismatch: expected %h, actual %h",
                   $time, oldest_result.value, out_result_value);
          error_count++;
        end
        if (out_overflow !== oldest_result.ovf) begin
          $display("%0t: overflow mismatch: expected %b, actual %b",
                   $time, oldest_result.ovf, out_overflow);
          error_count++;
        end
      end
    end
    out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= out_idle_pct);
  end

  task automatic write_coef(input int idx, input logic [COEF_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= IDX_W'(idx);
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < NUM_COEF) begin
      coef_shadow[idx] = data;
    end
  endtask

  task automatic push_request(input logic signed [COEF_W-1:0] x, input int k);
    deriv_request_t r;
    r.x = x;
    r.k = ORDER_W'(k);
    pending_requests.push_back(r);
  endtask

  // Hold until every request is sent and every result is back; sample
  // on the falling edge so the driver's updates have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_requests.size() != 0 || expected_results.size() != 0 || in_valid) begin
      @(negedge clk);
    end
  endtask

  function automatic logic signed [COEF_W-1:0] random_x();
    logic signed [COEF_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      4, 5:       v = $urandom;
      6:          v = ($signed($urandom_range(0, 16)) - 8) <<< 16;
      7: begin
        case ($urandom_range(0, 6))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = '0;
          3: v = 32'sh1;
          4: v = -32'sh1;
          5: v = Q_ONE;
          default: v = -Q_ONE;
        endcase
      end
      default:    v = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
    return v;
  endfunction

  initial begin
    int p;
    int i;
    int n;
    int style;
    logic [COEF_W-1:0] c;

    for (i = 0; i < NUM_COEF; i++) begin
      coef_shadow[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset coefficients give zero everywhere
    push_request(Q_MAX, 0);
    push_request(Q_MIN, 3);
    wait_idle();

    // Directed: small coefficients, every order, edge x values
    for (i = 0; i < NUM_COEF; i++) begin
      write_coef(i, (i - 3) <<< 16);
    end
    @(negedge clk);
    for (i = 0; i <= MAX_DEGREE; i++) begin
      push_request(Q_ONE, i);
    end
    push_request($urandom, MAX_DEGREE + 1);
    push_request($urandom, 15);
    push_request('0, 0);
    push_request(Q_MAX, 0);
    push_request(Q_MIN, 0);
    push_request(-32'sh1, 1);
    push_request(Q_MAX, MAX_DEGREE);
    push_request(Q_MIN, MAX_DEGREE - 1);
    wait_idle();

    // Directed: largest coefficients, out-of-range index writes are dropped
    for (i = 0; i < NUM_COEF; i++) begin
      write_coef(i, Q_MAX);
    end
    for (i = FIRST_UNUSED_INDEX; i < (1 << IDX_W); i++) begin
      write_coef(i, $urandom);
    end
    @(negedge clk);
    push_request(Q_MAX, 0);
    push_request(Q_MIN, 0);
    push_request(Q_MIN, 1);
    push_request('0, 0);
    push_request($urandom, MAX_DEGREE);
    push_request(Q_MAX, 12);
    wait_idle();

    // Random phases: rotate idle modes and coefficient sets
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin in_idle_pct = 0;  out_idle_pct = 0;  end
        1: begin in_idle_pct = 63; out_idle_pct = 0;  end
        2: begin in_idle_pct = 0;  out_idle_pct = 63; end
        default: begin in_idle_pct = 14; out_idle_pct = 14; end
      endcase
      for (i = 0; i < NUM_COEF; i++) begin
        style = p % 6;
        if (style == 4) begin
          style = $urandom_range(0, 3);
        end
        case (style)
          0: c = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
          1: c = $urandom;
          2: c = Q_MAX;
          3: c = Q_MIN;
          default: c = (i == MAX_DEGREE || i == 0) ? $urandom : 32'h0;
        endcase
        write_coef(i, c);
      end
      write_coef(FIRST_UNUSED_INDEX + $urandom_range(0, (1 << IDX_W) - 1 - NUM_COEF), $urandom);
      @(negedge clk);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        push_request(random_x(), ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15)
                                                            : $urandom_range(0, 7));
      end
      wait_idle();
    end

    // Back-pressure: stall the output while requests keep coming
    for (i = 0; i < NUM_COEF; i++) begin
      write_coef(i, $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    end
    @(negedge clk);
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_trigger++;
    for (n = 0; n < PRESSURE_ITEMS; n++) begin
      push_request(random_x(), $urandom_range(0, 15));
    end
    wait_idle();

    // Drain: allow a spurious late result to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("polynomial_derivative_evaluator_tb: PASS");
    end else begin
      $display("polynomial_derivative_evaluator_tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("polynomial_derivative_evaluator_tb: FAIL");
    $finish;
  end

endmodule
